### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and arithmetic helpers shared by the environmental
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Pipeline depths
  localparam int FrontStages = 12;
  localparam int DivSteps    = 64;

  // Compensation constants
  localparam logic [32:0] TfineOffPres = 33'd128000;
  localparam logic [31:0] TfineOffHum  = 32'd76800;
  localparam logic [20:0] PresFull     = 21'd1048576;
  localparam logic [63:0] PresScale    = 64'd3125;
  localparam logic [63:0] PresBias     = 64'd1 << 47;
  localparam logic [31:0] HumRound     = 32'd16384;
  localparam logic [31:0] HumInnerOff  = 32'd32768;
  localparam logic [31:0] HumRhsOff    = 32'd2097152;
  localparam logic [31:0] HumRhsRound  = 32'd8192;
  localparam logic [31:0] HumMax       = 32'd419430400;
  localparam logic [31:0] TempRound    = 32'd128;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgTempCalib   = 2'd0,
    CfgPresCalibLo = 2'd1,
    CfgPresCalibHi = 2'd2,
    CfgHumCalib    = 2'd3
  } cfg_idx_e;

  // Raw sample set
  typedef struct packed {
    logic [7:0] pressure_msb;
    logic [7:0] pressure_lsb;
    logic [7:0] pressure_xlsb;
    logic [7:0] temperature_msb;
    logic [7:0] temperature_lsb;
    logic [7:0] temperature_xlsb;
    logic [7:0] humidity_msb;
    logic [7:0] humidity_lsb;
  } esc_in_t;

  // Compensated result
  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [23:0] fine_temperature;
    logic signed [31:0] pressure_q24_8;
    logic               pressure_invalid;
    logic        [16:0] humidity_q22_10;
  } esc_out_t;

  // Calibration words
  typedef struct packed {
    logic [63:0] temp;
    logic [63:0] pres_lo;
    logic [63:0] pres_hi;
    logic [63:0] hum;
  } calib_t;

  // Divider operands (magnitudes)
  typedef struct packed {
    logic [63:0] nmag;
    logic [63:0] dmag;
  } div_op_t;

  // Values riding along with the division
  typedef struct packed {
    logic [18:0] temp;
    logic [23:0] tfine;
    logic [16:0] hum;
    logic        qneg;
    logic        invalid;
  } side_t;

  // Low 32 bits of a 32x32 product
  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    return a * b;
  endfunction

  // 64-bit word times signed 16-bit coefficient, modulo 2^64
  function automatic logic [63:0] mul64s16(logic [63:0] x, logic [15:0] c);
    logic [63:0] cx;
    cx = {{48{c[15]}}, c};
    return x * cx;
  endfunction

  // 64-bit word times unsigned 16-bit coefficient, modulo 2^64
  function automatic logic [63:0] mul64u16(logic [63:0] x, logic [15:0] c);
    logic [63:0] cx;
    cx = {48'd0, c};
    return x * cx;
  endfunction

endpackage

### rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of one raw temperature, pressure and humidity
// sample set into calibrated readings.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_item_i  (esc_in_t)
//  out      output     out_valid_o / out_stall_i  out_item_o (esc_out_t)
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One item per cycle unless a result is stalled; 12 front stages, 64 divider stages
//  (one quotient bit each, the 64-bit pressure division sets the depth) and
//  6 back stages including the result register.
//  Reset clears all valid bits and the four calibration words.
//  A stalled result freezes the whole pipeline, nothing is dropped.
// ----------------------------------------------------------------------------
module env_sensor_compensation import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  esc_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output esc_out_t    out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  calib_t      cal_q;
  logic        adv;
  logic        fr_valid, dv_valid;
  div_op_t     fr_op;
  side_t       fr_side, dv_side;
  logic [63:0] dv_quot;

  // Pipeline moves unless a result is held
  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTempCalib:   cal_q.temp    <= cfg_data_i;
        CfgPresCalibLo: cal_q.pres_lo <= cfg_data_i;
        CfgPresCalibHi: cal_q.pres_hi <= cfg_data_i;
        CfgHumCalib:    cal_q.hum     <= cfg_data_i;
      endcase
    end
  end

  esc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .cal_i   (cal_q),
    .valid_o (fr_valid),
    .op_o    (fr_op),
    .side_o  (fr_side)
  );

  esc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .op_i    (fr_op),
    .side_i  (fr_side),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  esc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_valid),
    .quot_i  (dv_quot),
    .side_i  (dv_side),
    .cal_i   (cal_q),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

endmodule

### rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Temperature, humidity and pressure pre-division stages. Produces the
// divider operands plus the finished temperature and humidity.
// ----------------------------------------------------------------------------
module esc_front import esc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    valid_i,
  input  esc_in_t item_i,
  input  calib_t  cal_i,
  output logic    valid_o,
  output div_op_t op_o,
  output side_t   side_o
);

  // Calibration fields
  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  logic [7:0]  h1, h3, h6;
  logic [15:0] h2;
  logic [11:0] h4, h5;

  assign t1 = cal_i.temp[15:0];
  assign t2 = cal_i.temp[31:16];
  assign t3 = cal_i.temp[47:32];
  assign p1 = cal_i.temp[63:48];
  assign p2 = cal_i.pres_lo[15:0];
  assign p3 = cal_i.pres_lo[31:16];
  assign p4 = cal_i.pres_lo[47:32];
  assign p5 = cal_i.pres_lo[63:48];
  assign p6 = cal_i.pres_hi[15:0];
  assign h1 = cal_i.hum[7:0];
  assign h2 = cal_i.hum[23:8];
  assign h3 = cal_i.hum[31:24];
  assign h4 = cal_i.hum[43:32];
  assign h5 = cal_i.hum[55:44];
  assign h6 = cal_i.hum[63:56];

  logic [FrontStages-1:0] vld_q;

  // Stage registers
  logic [31:0] s1_v1p_q, s1_dd_q, s1_v1p_d, s1_dd_d;
  logic [19:0] s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q, s5_adcp_q, s6_adcp_q, s7_adcp_q;
  logic [15:0] s1_adch_q, s2_adch_q, s3_adch_q, s4_adch_q, s5_adch_q;
  logic [31:0] s2_v1_q, s2_v2p_q, s2_v1_d, s2_v2p_d;
  logic [31:0] s3_tfine_q, s3_tfine_d;
  logic [18:0] s4_temp_q, s4_temp_d;
  logic [23:0] s4_tf_q;
  logic [32:0] s4_a_q, s4_a_d;
  logic [31:0] s4_amag_q, s4_amag_d, s4_hv_q, s4_hv_d;
  logic [63:0] s5_aa_q, s5_ap5_q, s5_ap2_q, s5_aa_d, s5_ap5_d, s5_ap2_d;
  logic [31:0] s5_m5_q, s5_ip_q, s5_i2p_q, s5_m5_d, s5_ip_d, s5_i2p_d;
  logic [63:0] s6_b6_q, s6_c3_q, s6_ap5_q, s6_ap2_q, s6_b6_d, s6_c3_d;
  logic [31:0] s6_lhs_q, s6_inner_q, s6_inner2_q, s6_lhs_d, s6_inner_d, s6_inner2_d;
  logic [63:0] s7_bsum_q, s7_acomb_q, s7_bsum_d, s7_acomb_d;
  logic [31:0] s7_ii_q, s7_lhs_q, s7_ii_d;
  logic [63:0] s8_x_q, s8_n0_q, s8_x_d, s8_n0_d;
  logic [31:0] s8_rp_q, s8_lhs_q, s8_rp_d;
  logic [63:0] s9_den_q, s9_n0_q, s9_den_d;
  logic [31:0] s9_rhs_q, s9_lhs_q, s9_rhs_d;
  logic [63:0] s10_num_q, s10_den_q, s10_num_d;
  logic [31:0] s10_vv_q, s10_vv_d;
  logic [63:0] s11_nmag_q, s11_dmag_q, s11_nmag_d, s11_dmag_d;
  logic        s11_qneg_q, s11_inval_q, s11_qneg_d, s11_inval_d;
  logic [31:0] s11_ss_q, s11_vv_q, s11_ss_d;
  logic [63:0] s12_nmag_q, s12_dmag_q;
  logic        s12_qneg_q, s12_inval_q;
  logic [16:0] s12_hum_q, s12_hum_d;
  logic [18:0] tmp_q [5:12];
  logic [23:0] tf_q  [5:12];

  // Combinational stage logic
  always_comb begin
    logic [19:0] adc_t;
    logic [31:0] x1, d, t5, vs, sq, hv_sum;
    logic [32:0] aneg;
    logic [20:0] pdiff;
    adc_t = {item_i.temperature_msb, item_i.temperature_lsb, item_i.temperature_xlsb[7:4]};

    // temperature
    x1       = {15'd0, adc_t[19:3]} - {15'd0, t1, 1'b0};
    d        = {16'd0, adc_t[19:4]} - {16'd0, t1};
    s1_v1p_d = mul32(x1, {{16{t2[15]}}, t2});
    s1_dd_d  = mul32(d, d);
    s2_v1_d  = $signed(s1_v1p_q) >>> 11;
    s2_v2p_d = mul32($signed(s1_dd_q) >>> 12, {{16{t3[15]}}, t3});
    s3_tfine_d = s2_v1_q + $unsigned($signed(s2_v2p_q) >>> 14);
    t5        = {s3_tfine_q[29:0], 2'b00} + s3_tfine_q + TempRound;
    s4_temp_d = t5[26:8];

    // pressure offset and humidity offset
    s4_a_d    = {s3_tfine_q[31], s3_tfine_q} - TfineOffPres;
    aneg      = -s4_a_d;
    s4_amag_d = s4_a_d[32] ? aneg[31:0] : s4_a_d[31:0];
    s4_hv_d   = s3_tfine_q - TfineOffHum;

    // pressure products
    s5_aa_d  = 64'(s4_amag_q) * 64'(s4_amag_q);
    s5_ap5_d = mul64s16({{31{s4_a_q[32]}}, s4_a_q}, p5);
    s5_ap2_d = mul64s16({{31{s4_a_q[32]}}, s4_a_q}, p2);
    s6_b6_d  = mul64s16(s5_aa_q, p6);
    s6_c3_d  = mul64s16(s5_aa_q, p3);
    s7_bsum_d  = s6_b6_q + {s6_ap5_q[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
    s7_acomb_d = $unsigned($signed(s6_c3_q) >>> 8) + {s6_ap2_q[51:0], 12'd0};
    s8_x_d   = s7_acomb_q + PresBias;
    pdiff    = PresFull - {1'b0, s7_adcp_q};
    s8_n0_d  = {12'd0, pdiff, 31'd0} - s7_bsum_q;
    s9_den_d  = $signed(mul64u16(s8_x_q, p1)) >>> 33;
    s10_num_d = s9_n0_q * PresScale;

    // divider setup
    s11_qneg_d  = s10_num_q[63] ^ s10_den_q[63];
    s11_nmag_d  = s10_num_q[63] ? -s10_num_q : s10_num_q;
    s11_dmag_d  = s10_den_q[63] ? -s10_den_q : s10_den_q;
    s11_inval_d = (s10_den_q == 64'd0);

    // humidity
    s5_m5_d  = mul32({{20{h5[11]}}, h5}, s4_hv_q);
    s5_ip_d  = mul32(s4_hv_q, {{24{h6[7]}}, h6});
    s5_i2p_d = mul32(s4_hv_q, {24'd0, h3});
    hv_sum   = {2'b00, s5_adch_q, 14'd0} - {h4, 20'd0} - s5_m5_q + HumRound;
    s6_lhs_d    = $signed(hv_sum) >>> 15;
    s6_inner_d  = $signed(s5_ip_q) >>> 10;
    s6_inner2_d = $unsigned($signed(s5_i2p_q) >>> 11) + HumInnerOff;
    s7_ii_d  = mul32(s6_inner_q, s6_inner2_q);
    s8_rp_d  = mul32($unsigned($signed(s7_ii_q) >>> 10) + HumRhsOff, {{16{h2[15]}}, h2});
    s9_rhs_d = $signed(s8_rp_q + HumRhsRound) >>> 14;
    s10_vv_d = mul32(s9_lhs_q, s9_rhs_q);
    vs       = $signed(s10_vv_q) >>> 15;
    s11_ss_d = mul32(vs, vs);
    sq       = mul32($signed(s11_ss_q) >>> 7, {24'd0, h1});
    vs       = s11_vv_q - $unsigned($signed(sq) >>> 4);
    if (vs[31]) begin
      vs = 32'd0;
    end else if (vs > HumMax) begin
      vs = HumMax;
    end
    s12_hum_d = vs[28:12];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[FrontStages-2:0], valid_i};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_v1p_q  <= s1_v1p_d;
      s1_dd_q   <= s1_dd_d;
      s1_adcp_q <= {item_i.pressure_msb, item_i.pressure_lsb, item_i.pressure_xlsb[7:4]};
      s1_adch_q <= {item_i.humidity_msb, item_i.humidity_lsb};

      s2_v1_q   <= s2_v1_d;
      s2_v2p_q  <= s2_v2p_d;
      s2_adcp_q <= s1_adcp_q;
      s2_adch_q <= s1_adch_q;

      s3_tfine_q <= s3_tfine_d;
      s3_adcp_q  <= s2_adcp_q;
      s3_adch_q  <= s2_adch_q;

      s4_temp_q <= s4_temp_d;
      s4_tf_q   <= s3_tfine_q[23:0];
      s4_a_q    <= s4_a_d;
      s4_amag_q <= s4_amag_d;
      s4_hv_q   <= s4_hv_d;
      s4_adcp_q <= s3_adcp_q;
      s4_adch_q <= s3_adch_q;

      s5_aa_q   <= s5_aa_d;
      s5_ap5_q  <= s5_ap5_d;
      s5_ap2_q  <= s5_ap2_d;
      s5_m5_q   <= s5_m5_d;
      s5_ip_q   <= s5_ip_d;
      s5_i2p_q  <= s5_i2p_d;
      s5_adcp_q <= s4_adcp_q;
      s5_adch_q <= s4_adch_q;

      s6_b6_q     <= s6_b6_d;
      s6_c3_q     <= s6_c3_d;
      s6_ap5_q    <= s5_ap5_q;
      s6_ap2_q    <= s5_ap2_q;
      s6_lhs_q    <= s6_lhs_d;
      s6_inner_q  <= s6_inner_d;
      s6_inner2_q <= s6_inner2_d;
      s6_adcp_q   <= s5_adcp_q;

      s7_bsum_q  <= s7_bsum_d;
      s7_acomb_q <= s7_acomb_d;
      s7_ii_q    <= s7_ii_d;
      s7_lhs_q   <= s6_lhs_q;
      s7_adcp_q  <= s6_adcp_q;

      s8_x_q   <= s8_x_d;
      s8_n0_q  <= s8_n0_d;
      s8_rp_q  <= s8_rp_d;
      s8_lhs_q <= s7_lhs_q;

      s9_den_q <= s9_den_d;
      s9_n0_q  <= s8_n0_q;
      s9_rhs_q <= s9_rhs_d;
      s9_lhs_q <= s8_lhs_q;

      s10_num_q <= s10_num_d;
      s10_den_q <= s9_den_q;
      s10_vv_q  <= s10_vv_d;

      s11_nmag_q  <= s11_nmag_d;
      s11_dmag_q  <= s11_dmag_d;
      s11_qneg_q  <= s11_qneg_d;
      s11_inval_q <= s11_inval_d;
      s11_ss_q    <= s11_ss_d;
      s11_vv_q    <= s10_vv_q;

      s12_nmag_q  <= s11_nmag_q;
      s12_dmag_q  <= s11_dmag_q;
      s12_qneg_q  <= s11_qneg_q;
      s12_inval_q <= s11_inval_q;
      s12_hum_q   <= s12_hum_d;

      // temperature results ride along
      tmp_q[5] <= s4_temp_q;
      tf_q[5]  <= s4_tf_q;
      for (int k = 6; k <= 12; k++) begin
        tmp_q[k] <= tmp_q[k-1];
        tf_q[k]  <= tf_q[k-1];
      end
    end
  end

  assign valid_o        = vld_q[FrontStages-1];
  assign op_o.nmag      = s12_nmag_q;
  assign op_o.dmag      = s12_dmag_q;
  assign side_o.temp    = tmp_q[12];
  assign side_o.tfine   = tf_q[12];
  assign side_o.hum     = s12_hum_q;
  assign side_o.qneg    = s12_qneg_q;
  assign side_o.invalid = s12_inval_q;

endmodule

### rtl/esc_divider.sv
// ----------------------------------------------------------------------------
// esc_divider
// Pipelined unsigned 64/64 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_divider import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  div_op_t     op_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [63:0] quot_o,
  output side_t       side_o
);

  logic        vld_q  [DivSteps];
  logic [63:0] rem_q  [DivSteps];
  logic [63:0] nq_q   [DivSteps];
  logic [63:0] den_q  [DivSteps];
  side_t       side_q [DivSteps];
  logic [63:0] rem_d  [DivSteps];
  logic [63:0] nq_d   [DivSteps];

  // One compare-subtract per stage
  always_comb begin
    logic [63:0] rem_in, nq_in, den_in;
    logic [64:0] rr, diff;
    logic        ge;
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        rem_in = '0;
        nq_in  = op_i.nmag;
        den_in = op_i.dmag;
      end else begin
        rem_in = rem_q[k-1];
        nq_in  = nq_q[k-1];
        den_in = den_q[k-1];
      end
      rr       = {rem_in, nq_in[63]};
      diff     = rr - {1'b0, den_in};
      ge       = (rr >= {1'b0, den_in});
      rem_d[k] = ge ? diff[63:0] : rr[63:0];
      nq_d[k]  = {nq_in[62:0], ge};
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivSteps; k++) vld_q[k] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < DivSteps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q[0]  <= op_i.dmag;
      side_q[0] <= side_i;
      for (int k = 1; k < DivSteps; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < DivSteps; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quot_o  = nq_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];

endmodule

### rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Pressure correction after the division and the result register.
// ----------------------------------------------------------------------------
module esc_back import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [63:0] quot_i,
  input  side_t       side_i,
  input  calib_t      cal_i,
  output logic        valid_o,
  output esc_out_t    item_o
);

  localparam int Stages = 6;

  logic [15:0] p7, p8, p9;
  assign p7 = cal_i.pres_hi[31:16];
  assign p8 = cal_i.pres_hi[47:32];
  assign p9 = cal_i.pres_hi[63:48];

  logic [Stages-1:0] vld_q;
  side_t       side_q [1:5];
  logic [63:0] b1_p_q, b2_p_q, b3_p_q, b4_p_q, b1_p_d;
  logic [51:0] b2_hh_q, b2_hh_d;
  logic [50:0] b2_hl_q, b2_hl_d;
  logic [49:0] b2_ll_q, b2_ll_d;
  logic [63:0] b2_c2p_q, b2_c2p_d;
  logic [63:0] b3_qq_q, b3_c2_q, b3_qq_d, b3_c2_d;
  logic [63:0] b4_c1p_q, b4_c2_q, b4_c1p_d;
  logic [63:0] b5_sum_q, b5_sum_d;
  esc_out_t    out_q, out_d;

  always_comb begin
    logic [63:0] qs, qm;
    logic [31:0] pres;
    // restore quotient sign
    b1_p_d = side_i.qneg ? -quot_i : quot_i;
    // q squared from the 26-bit upper and 25-bit lower parts of |p >> 13|
    qs = $signed(b1_p_q) >>> 13;
    qm = qs[63] ? -qs : qs;
    b2_hh_d  = 52'(qm[50:25]) * 52'(qm[50:25]);
    b2_hl_d  = 51'(qm[50:25]) * 51'(qm[24:0]);
    b2_ll_d  = 50'(qm[24:0]) * 50'(qm[24:0]);
    b2_c2p_d = mul64s16(b1_p_q, p8);
    b3_qq_d  = {b2_hh_q[13:0], 50'd0} + {b2_hl_q[37:0], 26'd0} + {14'd0, b2_ll_q};
    b3_c2_d  = $signed(b2_c2p_q) >>> 19;
    b4_c1p_d = mul64s16(b3_qq_q, p9);
    b5_sum_d = b4_p_q + $unsigned($signed(b4_c1p_q) >>> 25) + b4_c2_q;
    // final scaling and offset, low 32 bits
    pres = b5_sum_q[39:8] + {{12{p7[15]}}, p7, 4'd0};
    out_d.temperature_centi = side_q[5].temp;
    out_d.fine_temperature  = side_q[5].tfine;
    out_d.pressure_q24_8    = side_q[5].invalid ? 32'd0 : pres;
    out_d.pressure_invalid  = side_q[5].invalid;
    out_d.humidity_q22_10   = side_q[5].hum;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b1_p_q   <= b1_p_d;
      b2_p_q   <= b1_p_q;
      b2_hh_q  <= b2_hh_d;
      b2_hl_q  <= b2_hl_d;
      b2_ll_q  <= b2_ll_d;
      b2_c2p_q <= b2_c2p_d;
      b3_p_q   <= b2_p_q;
      b3_qq_q  <= b3_qq_d;
      b3_c2_q  <= b3_c2_d;
      b4_p_q   <= b3_p_q;
      b4_c1p_q <= b4_c1p_d;
      b4_c2_q  <= b3_c2_q;
      b5_sum_q <= b5_sum_d;
      out_q    <= out_d;
      side_q[1] <= side_i;
      for (int k = 2; k <= 5; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign item_o  = out_q;

endmodule

### verif/env_sensor_compensation_tb.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_tb
// Drives raw sample sets through the compensation pipeline under several
// calibration settings with random input gaps and random output stalls, and
// checks every result against a bit-exact integer model of the compensation.
// ----------------------------------------------------------------------------
module env_sensor_compensation_tb;
  import esc_pkg::*;

  // Arithmetic right shifts on raw bit patterns
  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Compensation of one sample set with the given calibration
  function automatic esc_out_t compensate(esc_in_t s, calib_t c);
    logic [31:0] adc_p, adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, d, v2, tfine, temp, v, lhs, inner, inner2, rhs, sq;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, tf64, a, b, p, q, c1, c2;
    logic [63:0] pres, na, da, qm;
    esc_out_t r;
    adc_p = {12'd0, s.pressure_msb, s.pressure_lsb, s.pressure_xlsb[7:4]};
    adc_t = {12'd0, s.temperature_msb, s.temperature_lsb, s.temperature_xlsb[7:4]};
    adc_h = {16'd0, s.humidity_msb, s.humidity_lsb};
    t1 = {16'd0, c.temp[15:0]};
    t2 = {{16{c.temp[31]}}, c.temp[31:16]};
    t3 = {{16{c.temp[47]}}, c.temp[47:32]};
    p1 = {48'd0, c.temp[63:48]};
    p2 = sx16(c.pres_lo[15:0]);  p3 = sx16(c.pres_lo[31:16]);
    p4 = sx16(c.pres_lo[47:32]); p5 = sx16(c.pres_lo[63:48]);
    p6 = sx16(c.pres_hi[15:0]);  p7 = sx16(c.pres_hi[31:16]);
    p8 = sx16(c.pres_hi[47:32]); p9 = sx16(c.pres_hi[63:48]);
    h1 = {24'd0, c.hum[7:0]};
    h2 = {{16{c.hum[23]}}, c.hum[23:8]};
    h3 = {24'd0, c.hum[31:24]};
    h4 = {{20{c.hum[43]}}, c.hum[43:32]};
    h5 = {{20{c.hum[55]}}, c.hum[55:44]};
    h6 = {{24{c.hum[63]}}, c.hum[63:56]};
    // temperature
    v1 = asr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tfine = v1 + v2;
    temp = asr32(tfine * 32'd5 + 32'd128, 8);
    // pressure
    tf64 = {{32{tfine[31]}}, tfine};
    a = tf64 - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr64(a * a * p3, 8) + ((a * p2) << 12);
    a = asr64(((64'd1 << 47) + a) * p1, 33);
    pres = '0;
    r.pressure_invalid = 1'b1;
    if (a != 0) begin
      p = 64'd1048576 - {32'd0, adc_p};
      na = ((p << 31) - b) * 64'd3125;
      da = a;
      qm = (na[63] ? -na : na) / (da[63] ? -da : da);
      p = (na[63] != da[63]) ? -qm : qm;
      q = asr64(p, 13);
      c1 = asr64(p9 * q * q, 25);
      c2 = asr64(p8 * p, 19);
      pres = asr64(p + c1 + c2, 8) + (p7 << 4);
      r.pressure_invalid = 1'b0;
    end
    // humidity
    v = tfine - 32'd76800;
    lhs = asr32((adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
    inner = asr32(v * h6, 10);
    inner2 = asr32(v * h3, 11) + 32'd32768;
    rhs = asr32((asr32(inner * inner2, 10) + 32'd2097152) * h2 + 32'd8192, 14);
    v = lhs * rhs;
    sq = asr32(v, 15);
    v = v - asr32(asr32(sq * sq, 7) * h1, 4);
    if (v[31]) v = '0;
    if (v > 32'd419430400) v = 32'd419430400;
    r.temperature_centi = temp[18:0];
    r.fine_temperature = tfine[23:0];
    r.pressure_q24_8 = pres[31:0];
    r.humidity_q22_10 = v[28:12];
    return r;
  endfunction

  // Expected readings in order of acceptance
  class reading_board;
    esc_out_t pending[$];
    int errors;
    int checked;

    function void note_sample(esc_in_t s, calib_t c);
      pending.push_back(compensate(s, c));
    endfunction

    function void check_reading(esc_out_t got);
      esc_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.temperature_centi !== want.temperature_centi ||
          got.fine_temperature !== want.fine_temperature ||
          got.pressure_q24_8 !== want.pressure_q24_8 ||
          got.pressure_invalid !== want.pressure_invalid ||
          got.humidity_q22_10 !== want.humidity_q22_10) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: exp t=%h f=%h p=%h i=%b h=%h got t=%h f=%h p=%h i=%b h=%h",
                   checked, want.temperature_centi, want.fine_temperature,
                   want.pressure_q24_8, want.pressure_invalid, want.humidity_q22_10,
                   got.temperature_centi, got.fine_temperature, got.pressure_q24_8,
                   got.pressure_invalid, got.humidity_q22_10);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  esc_in_t     in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  esc_out_t    out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  reading_board board = new();
  calib_t cal = '0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  int sent = 0;
  int num_settings = 0;

  env_sensor_compensation u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Write one calibration register; the caller drops valid afterwards
  task automatic write_calib(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTempCalib:   cal.temp = val;
      CfgPresCalibLo: cal.pres_lo = val;
      CfgPresCalibHi: cal.pres_hi = val;
      default:        cal.hum = val;
    endcase
  endtask

  task automatic load_calib(logic [63:0] t, logic [63:0] pl, logic [63:0] ph, logic [63:0] h);
    write_calib(CfgTempCalib, t);
    write_calib(CfgPresCalibLo, pl);
    write_calib(CfgPresCalibHi, ph);
    write_calib(CfgHumCalib, h);
    cfg_valid_i <= 1'b0;
    num_settings++;
  endtask

  // Offer one sample set, optionally after a random gap; valid stays up
  task automatic send_sample(esc_in_t s, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sample(s, cal);
    sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic esc_in_t rand_sample();
    return {$urandom, $urandom};
  endfunction

  // Typical datasheet-like calibration with random perturbation
  task automatic typical_calib();
    logic [63:0] t, pl, ph, h;
    t = {16'd36477 + 16'($urandom_range(0, 2000)), 16'd50, 16'd26435, 16'd27504};
    pl = {16'hFFF9 - 16'($urandom_range(0, 3)), 16'd140, 16'd3024, 16'hD4D6};
    ph = {16'd6000, 16'hD80C, 16'd15500, 16'hFFF9};
    h = {8'd30, 12'd50, 12'd330, 8'd0, 16'd360, 8'd75};
    if ($urandom_range(0, 1)) h[7:0] = 8'($urandom);
    load_calib(t, pl, ph, h);
  endtask

  // Receiver: random stalls, one long hold-off
  initial begin
    int w;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (sent < 300 || sent > 1400) begin
        out_stall_i <= 1'b0;
      end else begin
        w = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w != 0) begin
          out_stall_i <= 1'b1;
          repeat (w - 1) @(posedge clk_i);
        end
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_reading(out_item_o);
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    esc_in_t s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset calibration: zero divisor gives invalid pressure
    send_sample('0, 0);
    send_sample('1, 0);
    drain();
    typical_calib();
    send_sample('0, 0);
    send_sample('1, 0);
    send_sample({8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 8'h66, 8'h2A}, 0);
    send_sample({8'h65, 8'h5A, 8'hCF, 8'h7E, 8'hED, 8'h0F, 8'h00, 8'h00}, 0);
    send_sample({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF}, 0);
    send_sample({8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00}, 0);
    drain();
    // Extreme calibrations: overflow and wraparound
    load_calib('1, '1, '1, '1);
    send_sample('0, 0);
    send_sample('1, 0);
    send_sample(rand_sample(), 0);
    drain();
    load_calib(64'h7FFF_8000_7FFF_0000, 64'h8000_7FFF_8000_7FFF,
               64'h7FFF_8000_7FFF_8000, 64'h7F80_0800_FF7F_FFFF);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), 0);
    drain();
    // Zero P1 with typical temperature values: divisor zero
    load_calib(64'h0000_0032_670A_8E7D, cal.pres_lo, cal.pres_hi, cal.hum);
    send_sample(rand_sample(), 0);
    drain();
    // Random phases, one under a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) typical_calib();
      else load_calib({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      if (ph == 2) long_hold = 1'b1;
      for (int i = 0; i < 270; i++) send_sample(rand_sample(), 1);
      drain();
    end
    $display("%0d sample sets over %0d calibration settings, %0d results checked",
             sent, num_settings, board.checked);
    $display("including zero divisor, extreme calibration and a long output hold-off");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", board.errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### files.f
rtl/esc_pkg.sv
rtl/esc_front.sv
rtl/esc_divider.sv
rtl/esc_back.sv
rtl/env_sensor_compensation.sv
verif/env_sensor_compensation_tb.sv
